[rtl/gdfs_pkg.sv]
// Package with shared constants and types for the depth-first search block.
`timescale 1ns / 1ps
`default_nettype none
package gdfs_pkg;
	localparam int MaxNodesDef = 32;
	localparam int MaxEdgesDef = 256;
	localparam int NodeW = 5;
	localparam int TimeW = 7;
	localparam int CountW = 6;
	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 6;
	localparam logic [CfgIdxW-1:0] RegNodeCount = 1'd0;
	localparam logic [CfgIdxW-1:0] RegUndirected = 1'd1;

	typedef struct packed {
		logic [NodeW-1:0] src;
		logic [NodeW-1:0] dst;
		logic store;
		logic drop;
		logic last;
	} edge_cmd_t;
endpackage
`default_nettype wire

[rtl/gdfs_front.sv]
// Front part: checks each edge beat against the node count.
`timescale 1ns / 1ps
`default_nettype none
module gdfs_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [gdfs_pkg::NodeW-1:0] src_node,
	input wire logic [gdfs_pkg::NodeW-1:0] dst_node,
	input wire logic edge_present,
	input wire logic last_edge,
	input wire logic [gdfs_pkg::CountW:0] n_act,
	output logic q_valid,
	input wire logic q_stall,
	output gdfs_pkg::edge_cmd_t q_cmd
);
	logic ok;
	logic [gdfs_pkg::CountW:0] s_ext, d_ext;

	assign s_ext = {2'b0, src_node};
	assign d_ext = {2'b0, dst_node};
	assign ok = (s_ext < n_act) && (d_ext < n_act);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_valid <= 1'b0;
		end else if (!q_valid || !q_stall) begin
			q_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			q_cmd.src <= src_node;
			q_cmd.dst <= dst_node;
			q_cmd.store <= edge_present && ok;
			q_cmd.drop <= edge_present && !ok;
			q_cmd.last <= last_edge;
		end
	end

	assign in_stall = q_valid && q_stall;
endmodule
`default_nettype wire

[rtl/gdfs_back.sv]
// Back part: edge memory, the stack walk and the record output.
`timescale 1ns / 1ps
`default_nettype none
module gdfs_back #(
	parameter int MAX_NODES = gdfs_pkg::MaxNodesDef,
	parameter int MAX_EDGES = gdfs_pkg::MaxEdgesDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_stall,
	input gdfs_pkg::edge_cmd_t q_cmd,
	input wire logic [gdfs_pkg::CountW:0] n_act,
	input wire logic undir,
	output logic out_valid,
	input wire logic out_stall,
	output logic [gdfs_pkg::NodeW-1:0] node_index,
	output logic [gdfs_pkg::TimeW-1:0] discover_time,
	output logic [gdfs_pkg::TimeW-1:0] finish_time,
	output logic cycle_found,
	output logic edge_overflow,
	output logic last_record
);
	localparam int EW = $clog2(MAX_EDGES + 1);
	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int NIW = $clog2(MAX_NODES);
	localparam int NW = gdfs_pkg::NodeW;
	localparam int TW = gdfs_pkg::TimeW;

	typedef enum logic [6:0] {
		S_LOAD = 7'b0000001,
		S_ROOT = 7'b0000010,
		S_TOP = 7'b0000100,
		S_RD = 7'b0001000,
		S_EDGE = 7'b0010000,
		S_EMIT = 7'b0100000,
		S_CLR = 7'b1000000
	} state_t;

	state_t state_q;
	logic [NW-1:0] mem_s [MAX_EDGES];
	logic [NW-1:0] mem_d [MAX_EDGES];
	logic [NW-1:0] rd_s_q, rd_d_q;
	logic [EW-1:0] held_q, k_q;
	logic [TW-1:0] disc_q [MAX_NODES];
	logic [TW-1:0] fin_q [MAX_NODES];
	logic [NW:0] par_q [MAX_NODES];
	logic [NW-1:0] stk_q [MAX_NODES];
	logic [NIW:0] sp_q;
	logic [NW:0] root_q;
	logic [NW-1:0] a_q;
	logic [TW-1:0] time_q;
	logic cyc_q, ovf_q;
	logic [NW:0] rec_q;

	logic full;
	logic [NW:0] se, de;
	logic sm, dm, fwd, bwd;
	logic [NW-1:0] v;
	logic hit;
	logic [NW:0] a_ext;

	assign full = (held_q == EW'(MAX_EDGES));
	assign q_stall = (state_q != S_LOAD);
	assign se = {1'b0, rd_s_q};
	assign de = {1'b0, rd_d_q};
	assign a_ext = {1'b0, a_q};
	assign sm = (rd_s_q == a_q);
	assign dm = (rd_d_q == a_q);
	assign fwd = sm;
	assign bwd = undir && dm;

	// Decide for the current edge whether it pushes a node, and which node it pushes.
	always_comb begin
		v = rd_d_q;
		hit = 1'b0;
		if (fwd) begin
			v = rd_d_q;
			hit = (disc_q[rd_d_q[NIW-1:0]] == '0);
		end
		if (!hit && bwd) begin
			v = rd_s_q;
			hit = (disc_q[rd_s_q[NIW-1:0]] == '0);
		end
	end

	function automatic logic cyc_of(input logic [NW-1:0] a, input logic [NW-1:0] w,
			input logic [TW-1:0] dw, input logic [TW-1:0] fw, input logic [NW:0] pa,
			input logic [NW:0] pw, input logic u);
		logic r;
		r = 1'b0;
		if (dw != '0) begin
			if (u) r = ({1'b0, w} != pa) && (pw != {1'b0, a});
			else r = (fw == '0);
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && q_valid && q_cmd.store && !full)
			begin
			mem_s[held_q[AW-1:0]] <= q_cmd.src;
			mem_d[held_q[AW-1:0]] <= q_cmd.dst;
		end
		rd_s_q <= mem_s[k_q[AW-1:0]];
		rd_d_q <= mem_d[k_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ROOT || (state_q == S_EDGE && (se < n_act) && (de < n_act)
				&& hit && (sp_q < (NIW+1)'(MAX_NODES)))) begin
			stk_q[sp_q[NIW-1:0]] <= (state_q == S_ROOT) ? root_q[NW-1:0] : v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			held_q <= '0;
			k_q <= '0;
			sp_q <= '0;
			root_q <= '0;
			a_q <= '0;
			time_q <= TW'(1);
			cyc_q <= 1'b0;
			ovf_q <= 1'b0;
			rec_q <= '0;
			out_valid <= 1'b0;
			node_index <= '0;
			discover_time <= '0;
			finish_time <= '0;
			cycle_found <= 1'b0;
			edge_overflow <= 1'b0;
			last_record <= 1'b0;
			for (int i = 0; i < MAX_NODES; i++) begin
				disc_q[i] <= '0;
				fin_q[i] <= '0;
				par_q[i] <= '1;
			end
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (q_valid) begin
						if (q_cmd.store && !full) held_q <= held_q + EW'(1);
						if (q_cmd.drop || (q_cmd.store && full)) ovf_q <= 1'b1;
						if (q_cmd.last) begin
							state_q <= S_ROOT;
							root_q <= '0;
						end
					end
				end
				S_ROOT: begin
					if (root_q >= n_act) begin
						state_q <= S_EMIT;
						rec_q <= '0;
					end else if (disc_q[root_q[NIW-1:0]] != '0) begin
						root_q <= root_q + 1'b1;
					end else begin
						sp_q <= (NIW+1)'(1);
						state_q <= S_TOP;
					end
				end
				S_TOP: begin
					if (sp_q == '0) begin
						root_q <= root_q + 1'b1;
						state_q <= S_ROOT;
					end else begin
						a_q <= stk_q[sp_q[NIW-1:0] - 1'b1];
						if (disc_q[stk_q[sp_q[NIW-1:0] - 1'b1][NIW-1:0]] == '0) begin
							disc_q[stk_q[sp_q[NIW-1:0] - 1'b1][NIW-1:0]] <= time_q;
							time_q <= time_q + 1'b1;
						end
						k_q <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (k_q >= held_q) begin
						fin_q[a_q[NIW-1:0]] <= time_q;
						time_q <= time_q + 1'b1;
						sp_q <= sp_q - 1'b1;
						state_q <= S_TOP;
					end else begin
						state_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					k_q <= k_q + EW'(1);
					state_q <= S_RD;
					if (!((se < n_act) && (de < n_act))) begin
						ovf_q <= 1'b1;
					end else begin
						if (fwd && cyc_of(a_q, rd_d_q, disc_q[rd_d_q[NIW-1:0]],
								fin_q[rd_d_q[NIW-1:0]], par_q[a_q[NIW-1:0]],
								par_q[rd_d_q[NIW-1:0]], undir))
							cyc_q <= 1'b1;
						if (bwd && !(fwd && disc_q[rd_d_q[NIW-1:0]] == '0)
								&& cyc_of(a_q, rd_s_q, disc_q[rd_s_q[NIW-1:0]],
								fin_q[rd_s_q[NIW-1:0]], par_q[a_q[NIW-1:0]],
								par_q[rd_s_q[NIW-1:0]], undir))
							cyc_q <= 1'b1;
						if (hit) begin
							par_q[v[NIW-1:0]] <= a_ext;
							if (sp_q < (NIW+1)'(MAX_NODES)) begin
								sp_q <= sp_q + 1'b1;
								state_q <= S_TOP;
							end else begin
								fin_q[a_q[NIW-1:0]] <= time_q;
								time_q <= time_q + 1'b1;
								sp_q <= sp_q - 1'b1;
								state_q <= S_TOP;
							end
						end
					end
				end
				S_EMIT: begin
					if (!out_valid || !out_stall) begin
						if (rec_q < n_act) begin
							out_valid <= 1'b1;
							node_index <= rec_q[NW-1:0];
							discover_time <= disc_q[rec_q[NIW-1:0]];
							finish_time <= fin_q[rec_q[NIW-1:0]];
							cycle_found <= cyc_q;
							edge_overflow <= ovf_q;
							last_record <= (rec_q + 1'b1 == n_act);
							rec_q <= rec_q + 1'b1;
						end else begin
							out_valid <= 1'b0;
							state_q <= S_CLR;
						end
					end
				end
				S_CLR: begin
					for (int i = 0; i < MAX_NODES; i++) begin
						disc_q[i] <= '0;
						fin_q[i] <= '0;
						par_q[i] <= '1;
					end
					held_q <= '0;
					sp_q <= '0;
					time_q <= TW'(1);
					cyc_q <= 1'b0;
					ovf_q <= 1'b0;
					state_q <= S_LOAD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= EW'(MAX_EDGES)) else $error("edge count above capacity");
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= (NIW+1)'(MAX_NODES)) else $error("stack above capacity");
	a_out_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_EMIT) else $error("beat outside output phase");
	a_load_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> !(held_q != $past(held_q) && $past(state_q) != S_LOAD
		&& $past(state_q) != S_CLR)) else $error("edge stored during search");
endmodule
`default_nettype wire

[rtl/graph_dfs_times_and_cycle_check_core.sv]
// Top level of the depth-first search block with discovery and finish times.
// Input beats carry one edge each; a beat with last_edge starts the search.
// Edges are range checked in a front stage and stored one per cycle in a
// back part while it loads; the back part holds an edge memory and a node
// stack and drops edges past capacity. After the last beat the walk scans
// the stored edges once per stack visit, in states S_RD and S_EDGE for each
// edge, so its length grows with nodes times edges. Then one output beat per
// node is given in ascending order, with last_record on the final one,
// followed by a clear of the node stores in state S_CLR. During search,
// output and clear the front stage takes one more beat and then stalls
// input. A stalled output beat holds until taken. Reset clears all
// control state and sets node_count to 32 and directed mode.
`timescale 1ns / 1ps
`default_nettype none
module graph_dfs_times_and_cycle_check_core #(
	parameter int MAX_NODES = gdfs_pkg::MaxNodesDef,
	parameter int MAX_EDGES = gdfs_pkg::MaxEdgesDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [gdfs_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [gdfs_pkg::CfgDataW-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [gdfs_pkg::NodeW-1:0] src_node,
	input wire logic [gdfs_pkg::NodeW-1:0] dst_node,
	input wire logic edge_present,
	input wire logic last_edge,
	output logic out_valid,
	input wire logic out_stall,
	output logic [gdfs_pkg::NodeW-1:0] node_index,
	output logic [gdfs_pkg::TimeW-1:0] discover_time,
	output logic [gdfs_pkg::TimeW-1:0] finish_time,
	output logic cycle_found,
	output logic edge_overflow,
	output logic last_record
);
	logic [gdfs_pkg::CountW-1:0] nc_q;
	logic und_q;
	logic [gdfs_pkg::CountW:0] n_act;
	logic q_valid, q_stall, fstall;
	gdfs_pkg::edge_cmd_t q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q <= gdfs_pkg::CountW'(32);
			und_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gdfs_pkg::RegNodeCount: nc_q <= cfg_data;
				gdfs_pkg::RegUndirected: und_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (nc_q == '0) n_act = (gdfs_pkg::CountW+1)'(1);
		else if ({1'b0, nc_q} > (gdfs_pkg::CountW+1)'(MAX_NODES))
			n_act = (gdfs_pkg::CountW+1)'(MAX_NODES);
		else n_act = {1'b0, nc_q};
	end

	gdfs_front u_front (
		.clk, .arst_n, .in_valid, .in_stall(fstall), .src_node, .dst_node,
		.edge_present, .last_edge, .n_act, .q_valid, .q_stall, .q_cmd
	);

	assign in_stall = fstall;

	gdfs_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_back (
		.clk, .arst_n, .q_valid, .q_stall, .q_cmd, .n_act, .undir(und_q),
		.out_valid, .out_stall, .node_index, .discover_time, .finish_time,
		.cycle_found, .edge_overflow, .last_record
	);
endmodule
`default_nettype wire

[sim/gdfs_checker.sv]
// Checker that predicts and compares the per-node records of the search block.
`timescale 1ns / 1ps
module gdfs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [gdfs_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [gdfs_pkg::CfgDataW-1:0] cfg_data,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic [gdfs_pkg::NodeW-1:0] src_node,
	input wire logic [gdfs_pkg::NodeW-1:0] dst_node,
	input wire logic edge_present,
	input wire logic last_edge,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [gdfs_pkg::NodeW-1:0] node_index,
	input wire logic [gdfs_pkg::TimeW-1:0] discover_time,
	input wire logic [gdfs_pkg::TimeW-1:0] finish_time,
	input wire logic cycle_found,
	input wire logic edge_overflow,
	input wire logic last_record,
	output int errors,
	output int pending
);
	localparam int NN = gdfs_pkg::MaxNodesDef;
	localparam int NE = gdfs_pkg::MaxEdgesDef;
	localparam logic [5:0] NoParent = 6'h3f;

	typedef struct {
		logic [gdfs_pkg::NodeW-1:0] node;
		logic [gdfs_pkg::TimeW-1:0] disc;
		logic [gdfs_pkg::TimeW-1:0] fin;
		logic cyc;
		logic ovf;
		logic lastr;
	} node_rec_t;

	node_rec_t node_records[$];

	logic [gdfs_pkg::CountW-1:0] cfg_nodes;
	logic cfg_undir;
	logic [gdfs_pkg::NodeW-1:0] edge_src[NE];
	logic [gdfs_pkg::NodeW-1:0] edge_dst[NE];
	int held;
	logic [gdfs_pkg::TimeW-1:0] disc_t[NN];
	logic [gdfs_pkg::TimeW-1:0] fin_t[NN];
	logic [5:0] parent[NN];
	logic [gdfs_pkg::NodeW-1:0] stack[NN];
	int depth;
	logic [gdfs_pkg::TimeW-1:0] clock_t;
	logic cyc_seen;
	logic ovf_seen;

	assign pending = node_records.size();

	function automatic int active_count();
		if (cfg_nodes == 0) return 1;
		if (cfg_nodes > NN) return NN;
		return int'(cfg_nodes);
	endfunction

	function automatic void clear_graph();
		held = 0;
		depth = 0;
		clock_t = 1;
		cyc_seen = 0;
		ovf_seen = 0;
		for (int i = 0; i < NN; i++) begin
			disc_t[i] = 0;
			fin_t[i] = 0;
			parent[i] = NoParent;
		end
	endfunction

	function automatic bit reach(int a, int v);
		if (disc_t[v] != 0) begin
			if (cfg_undir) begin
				if (v != parent[a] && parent[v] != a)
					cyc_seen = 1;
			end else if (fin_t[v] == 0) begin
				cyc_seen = 1;
			end
			return 0;
		end
		parent[v] = 6'(a);
		return 1;
	endfunction

	function automatic int next_child(int a, int n);
		int s;
		int d;
		for (int k = 0; k < held; k++) begin
			s = edge_src[k];
			d = edge_dst[k];
			if (s >= n || d >= n) begin
				ovf_seen = 1;
				continue;
			end
			if (s == a && reach(a, d)) return d;
			if (cfg_undir && d == a && reach(a, s)) return s;
		end
		return -1;
	endfunction

	function automatic void walk_and_predict();
		int n;
		int a;
		int v;
		node_rec_t r;
		n = active_count();
		for (int i = 0; i < n; i++) begin
			if (disc_t[i] != 0) continue;
			depth = 1;
			stack[0] = gdfs_pkg::NodeW'(i);
			while (depth > 0) begin
				a = stack[depth-1];
				if (disc_t[a] == 0) begin
					disc_t[a] = clock_t;
					clock_t++;
				end
				v = next_child(a, n);
				if (v >= 0 && depth < NN) begin
					stack[depth] = gdfs_pkg::NodeW'(v);
					depth++;
				end else begin
					fin_t[a] = clock_t;
					clock_t++;
					depth--;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			r.node = gdfs_pkg::NodeW'(i);
			r.disc = disc_t[i];
			r.fin = fin_t[i];
			r.cyc = cyc_seen;
			r.ovf = ovf_seen;
			r.lastr = (i == n - 1);
			node_records.insert(node_records.size(), r);
		end
		clear_graph();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		node_rec_t e;
		int n;
		if (!arst_n) begin
			cfg_nodes = 32;
			cfg_undir = 0;
			errors = 0;
			clear_graph();
			node_records.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (node_records.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected record node %0d at %0t", node_index, $realtime);
				end else begin
					e = node_records.pop_front();
					if (node_index !== e.node || discover_time !== e.disc ||
							finish_time !== e.fin || cycle_found !== e.cyc ||
							edge_overflow !== e.ovf || last_record !== e.lastr) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp node %0d d %0d f %0d c %0b o %0b l %0b,",
								e.node, e.disc, e.fin, e.cyc, e.ovf, e.lastr,
								" got node %0d d %0d f %0d c %0b o %0b l %0b",
								node_index, discover_time, finish_time, cycle_found,
								edge_overflow, last_record);
					end
				end
			end
			if (in_valid && !in_stall) begin
				n = active_count();
				if (edge_present) begin
					if (src_node >= n || dst_node >= n || held >= NE) begin
						ovf_seen = 1;
					end else begin
						edge_src[held] = src_node;
						edge_dst[held] = dst_node;
						held++;
					end
				end
				if (last_edge)
					walk_and_predict();
			end
			if (cfg_we) begin
				if (cfg_index == gdfs_pkg::RegNodeCount)
					cfg_nodes = cfg_data;
				else if (cfg_index == gdfs_pkg::RegUndirected)
					cfg_undir = cfg_data[0];
			end
		end
	end
endmodule

[sim/tb.sv]
// Testbench top: drives edges and configuration, and gives the verdict.
`timescale 1ns / 1ps
module tb;
	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [gdfs_pkg::CfgIdxW-1:0] cfg_index = gdfs_pkg::RegNodeCount;
	logic [gdfs_pkg::CfgDataW-1:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [gdfs_pkg::NodeW-1:0] src_node = 0;
	logic [gdfs_pkg::NodeW-1:0] dst_node = 0;
	logic edge_present = 0;
	logic last_edge = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [gdfs_pkg::NodeW-1:0] node_index;
	logic [gdfs_pkg::TimeW-1:0] discover_time;
	logic [gdfs_pkg::TimeW-1:0] finish_time;
	logic cycle_found;
	logic edge_overflow;
	logic last_record;
	int errors;
	int pending;
	int cycles = 0;
	int sent = 0;
	int nodes_set = 32;

	always #6 clk = ~clk;

	graph_dfs_times_and_cycle_check_core u_dut (.*);

	gdfs_checker u_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Output back-pressure: quiet stretches, short stalls and a few long ones.
	initial begin
		int r;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			out_stall <= (r < 50);
			if (r < 8)
				repeat ($urandom_range(10, 40)) @(posedge clk);
			else if (r < 50)
				repeat ($urandom_range(1, 3)) @(posedge clk);
			else
				repeat ($urandom_range(1, 25)) @(posedge clk);
		end
	end

	task automatic send_beat(input int s, input int d, input bit p, input bit l);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 30);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		src_node <= gdfs_pkg::NodeW'(s);
		dst_node <= gdfs_pkg::NodeW'(d);
		edge_present <= p;
		last_edge <= l;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		sent++;
	endtask

	task automatic settle();
		in_valid <= 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [gdfs_pkg::CfgIdxW-1:0] idx, input int val);
		settle();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= gdfs_pkg::CfgDataW'(val);
		@(posedge clk);
		cfg_we <= 0;
		if (idx == gdfs_pkg::RegNodeCount)
			nodes_set = (val == 0) ? 1 : (val > 32) ? 32 : val;
	endtask

	task automatic random_graph(input int edges);
		int s;
		int d;
		for (int e = 0; e <= edges; e++) begin
			if ($urandom_range(0, 99) < 85) begin
				s = $urandom_range(0, nodes_set - 1);
				d = $urandom_range(0, nodes_set - 1);
			end else begin
				s = $urandom_range(0, 31);
				d = $urandom_range(0, 31);
			end
			if (e == edges)
				send_beat(s, d, $urandom_range(0, 1), 1);
			else
				send_beat(s, d, $urandom_range(0, 9) != 0, 0);
		end
	endtask

	initial begin
		int r;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset settings: directed, all 32 nodes, a back edge and a self-loop.
		send_beat(0, 31, 1, 0);
		send_beat(31, 0, 1, 0);
		send_beat(5, 5, 1, 0);
		send_beat(31, 31, 0, 1);
		// Empty graph over every node.
		send_beat(0, 0, 0, 1);

		// Undirected: parallel edge to the parent, a triangle, a range drop.
		write_reg(gdfs_pkg::RegNodeCount, 4);
		write_reg(gdfs_pkg::RegUndirected, 1);
		send_beat(0, 1, 1, 0);
		send_beat(1, 0, 1, 0);
		send_beat(1, 2, 1, 0);
		send_beat(2, 3, 1, 0);
		send_beat(3, 1, 1, 0);
		send_beat(5, 0, 1, 1);
		send_beat(2, 2, 1, 1);

		// Node count lowered after the edges were stored.
		write_reg(gdfs_pkg::RegUndirected, 0);
		write_reg(gdfs_pkg::RegNodeCount, 6);
		send_beat(4, 5, 1, 0);
		send_beat(0, 4, 1, 0);
		send_beat(0, 1, 1, 0);
		write_reg(gdfs_pkg::RegNodeCount, 3);
		send_beat(0, 0, 0, 1);

		// Zero and oversized node counts.
		write_reg(gdfs_pkg::RegNodeCount, 0);
		send_beat(0, 0, 1, 1);
		write_reg(gdfs_pkg::RegNodeCount, 63);
		send_beat(30, 31, 1, 1);

		while (sent < 60) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				r = $urandom_range(0, 99);
				write_reg(gdfs_pkg::RegNodeCount, (r < 8) ? 1 : (r < 16) ? 32 :
					(r < 20) ? 0 : (r < 24) ? $urandom_range(33, 63) :
					$urandom_range(2, 10));
				write_reg(gdfs_pkg::RegUndirected, $urandom_range(0, 1));
			end
			random_graph(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) :
				$urandom_range(0, 12));
		end

		// Edge store filled past capacity.
		write_reg(gdfs_pkg::RegNodeCount, 3);
		write_reg(gdfs_pkg::RegUndirected, $urandom_range(0, 1));
		for (int e = 0; e < 258; e++)
			send_beat($urandom_range(0, 2), $urandom_range(0, 2), 1, e == 257);

		settle();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
